// ===== hw/rtl/acbmp_pkg.sv =====
// Package for the container-to-BMP pixel stream block.
// Holds payload structs, parse phases, error codes and front/back job type.
package acbmp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [2:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } out_item_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ERR_TRUNCATED = 3'd2;
  localparam logic [2:0] ERR_ZERO_SIZE = 3'd3;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
  localparam logic [2:0] ERR_SHORT_HDR = 3'd5;

  localparam logic [1:0] CFG_MAX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAX_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MAX_PIXELS = 2'd2;

  localparam logic [31:0] MAX_PIXELS_RST = 32'd1431655746;
  localparam logic [63:0] WIDTH_LIMIT    = 64'd2147483647;
  localparam logic [63:0] HEIGHT_LIMIT   = 64'd715827881;
  localparam logic [63:0] HDR_FIXED_LEN  = 64'd36;
  localparam logic [63:0] PRE_SKIP_LEN   = 64'd12;

  localparam logic [7:0] BLK_HEADER  = 8'd1;
  localparam logic [7:0] BLK_CREDITS = 8'd2;
  localparam logic [7:0] BLK_CIFF    = 8'd3;

  typedef enum logic [12:0] {
    PH_TYPE     = 13'b0000000000001,
    PH_BLK_LEN  = 13'b0000000000010,
    PH_BLK_SKIP = 13'b0000000000100,
    PH_CIFF_LEN = 13'b0000000001000,
    PH_PRE_SKIP = 13'b0000000010000,
    PH_HSIZE    = 13'b0000000100000,
    PH_CSIZE    = 13'b0000001000000,
    PH_WIDTH    = 13'b0000010000000,
    PH_HEIGHT   = 13'b0000100000000,
    PH_CAPTION  = 13'b0001000000000,
    PH_CHECK    = 13'b0010000000000,
    PH_PIXELS   = 13'b0100000000000,
    PH_STOP     = 13'b1000000000000
  } phase_t;

  // One job from front to back: a pixel triple with optional padding, or an error.
  typedef struct packed {
    logic        is_err;
    logic [2:0]  err;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [1:0]  pad;
    logic        last;
    logic [15:0] width;
    logic [15:0] height;
  } job_t;

endpackage

// ===== hw/rtl/acbmp_front.sv =====
// Front end: parses the container byte stream and issues pixel or error jobs.
// Uses acbmp_pkg. The dimension check runs in its own phase (product registered).
module acbmp_front #(
  parameter int DIM_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  acbmp_pkg::in_item_t in_data,
  input  logic [15:0]         wid_cap,
  input  logic [15:0]         hgt_cap,
  input  logic [31:0]         max_pixels,
  output logic                job_valid,
  input  logic                job_full,
  output acbmp_pkg::job_t     job
);

  localparam logic [63:0] DIM_MASK = (64'd1 << DIM_BITS) - 64'd1;

  acbmp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] skip_r, skip_nxt;
  logic [63:0] hlen_r, hlen_nxt;
  logic [DIM_BITS-1:0] wid_r, wid_nxt, hgt_r, hgt_nxt;
  logic wov_r, wov_nxt, hov_r, hov_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [7:0]  c0_r, c0_nxt, c1_r, c1_nxt;
  logic [1:0]  ci_r, ci_nxt;
  logic        eof_r, eof_nxt;
  logic        chk_go_r, chk_go_nxt;
  logic [2*DIM_BITS-1:0] prod_r;

  logic [63:0] word;
  logic        acc_done, take, emit;
  logic [2:0]  err;
  logic [2:0]  chk_err;
  logic [DIM_BITS-1:0] col_inc, row_inc;
  logic [63:0] wid64, hgt64;

  assign word     = acc_r | ({56'd0, in_data.in_byte} << {idx_r, 3'b000});
  assign acc_done = (idx_r == 3'd7);
  assign wid64    = 64'(wid_r);
  assign hgt64    = 64'(hgt_r);
  assign col_inc  = col_r + 1'b1;
  assign row_inc  = row_r + 1'b1;
  // Go flag registers the check phase; the product is valid once it is set
  assign chk_go_nxt = (phase_r == acbmp_pkg::PH_CHECK);

  always_comb begin
    chk_err = acbmp_pkg::ERR_NONE;
    if ((wid_r == '0 && !wov_r) || (hgt_r == '0 && !hov_r)) begin
      chk_err = acbmp_pkg::ERR_ZERO_SIZE;
    end else if (wov_r || hov_r || wid64 > acbmp_pkg::WIDTH_LIMIT ||
                 hgt64 > acbmp_pkg::HEIGHT_LIMIT || wid64 > 64'(wid_cap) ||
                 hgt64 > 64'(hgt_cap) || 64'(prod_r) > 64'(max_pixels)) begin
      chk_err = acbmp_pkg::ERR_TOO_LARGE;
    end
  end

  // Check phase takes no input; pixel phase stalls on a full queue; stop phase swallows everything.
  assign in_stall = (phase_r == acbmp_pkg::PH_CHECK) ||
                    (phase_r == acbmp_pkg::PH_PIXELS && job_full);
  assign take     = in_valid && !in_stall;

  always_comb begin
    phase_nxt = phase_r; idx_nxt = idx_r; acc_nxt = acc_r; skip_nxt = skip_r;
    hlen_nxt = hlen_r; wid_nxt = wid_r; hgt_nxt = hgt_r; wov_nxt = wov_r;
    hov_nxt = hov_r; col_nxt = col_r; row_nxt = row_r; c0_nxt = c0_r;
    c1_nxt = c1_r; ci_nxt = ci_r; eof_nxt = eof_r;
    err = acbmp_pkg::ERR_NONE; emit = 1'b0;
    job = '0;
    if (phase_r == acbmp_pkg::PH_CHECK) begin
      // Hold the first check cycle while the product settles
      if (chk_go_r) begin
        if (chk_err != acbmp_pkg::ERR_NONE) begin
          err = chk_err;
        end else if (eof_r) begin
          err = acbmp_pkg::ERR_TRUNCATED;
        end else begin
          col_nxt = '0; row_nxt = '0; ci_nxt = 2'd0;
          phase_nxt = acbmp_pkg::PH_PIXELS;
        end
        if (err != acbmp_pkg::ERR_NONE) begin
          phase_nxt = acbmp_pkg::PH_STOP;
          emit = 1'b1;
        end
      end
    end else if (take && phase_r != acbmp_pkg::PH_STOP) begin
      if (phase_r == acbmp_pkg::PH_BLK_LEN || phase_r == acbmp_pkg::PH_CIFF_LEN ||
          phase_r == acbmp_pkg::PH_HSIZE || phase_r == acbmp_pkg::PH_CSIZE ||
          phase_r == acbmp_pkg::PH_WIDTH || phase_r == acbmp_pkg::PH_HEIGHT) begin
        acc_nxt = acc_done ? 64'd0 : word;
        idx_nxt = idx_r + 3'd1;
      end
      case (phase_r)
        acbmp_pkg::PH_TYPE: begin
          idx_nxt = 3'd0; acc_nxt = 64'd0;
          if (in_data.in_byte == acbmp_pkg::BLK_CIFF) begin
            phase_nxt = acbmp_pkg::PH_CIFF_LEN;
          end else if (in_data.in_byte == acbmp_pkg::BLK_HEADER ||
                       in_data.in_byte == acbmp_pkg::BLK_CREDITS) begin
            phase_nxt = acbmp_pkg::PH_BLK_LEN;
          end else begin
            err = acbmp_pkg::ERR_BAD_TYPE;
          end
        end
        acbmp_pkg::PH_BLK_LEN: if (acc_done) begin
          skip_nxt  = word;
          phase_nxt = (word != 64'd0) ? acbmp_pkg::PH_BLK_SKIP : acbmp_pkg::PH_TYPE;
        end
        acbmp_pkg::PH_BLK_SKIP: begin
          skip_nxt = skip_r - 64'd1;
          if (skip_r == 64'd1) phase_nxt = acbmp_pkg::PH_TYPE;
        end
        acbmp_pkg::PH_CIFF_LEN: if (acc_done) begin
          skip_nxt  = acbmp_pkg::PRE_SKIP_LEN;
          phase_nxt = acbmp_pkg::PH_PRE_SKIP;
        end
        acbmp_pkg::PH_PRE_SKIP: begin
          skip_nxt = skip_r - 64'd1;
          if (skip_r == 64'd1) phase_nxt = acbmp_pkg::PH_HSIZE;
        end
        acbmp_pkg::PH_HSIZE: if (acc_done) begin
          hlen_nxt = word; phase_nxt = acbmp_pkg::PH_CSIZE;
        end
        acbmp_pkg::PH_CSIZE: if (acc_done) phase_nxt = acbmp_pkg::PH_WIDTH;
        acbmp_pkg::PH_WIDTH: if (acc_done) begin
          wid_nxt = word[DIM_BITS-1:0]; wov_nxt = word > DIM_MASK;
          phase_nxt = acbmp_pkg::PH_HEIGHT;
        end
        acbmp_pkg::PH_HEIGHT: if (acc_done) begin
          hgt_nxt = word[DIM_BITS-1:0]; hov_nxt = word > DIM_MASK;
          if (hlen_r < acbmp_pkg::HDR_FIXED_LEN) begin
            err = acbmp_pkg::ERR_SHORT_HDR;
          end else begin
            skip_nxt = hlen_r - acbmp_pkg::HDR_FIXED_LEN;
            phase_nxt = (hlen_r == acbmp_pkg::HDR_FIXED_LEN) ? acbmp_pkg::PH_CHECK
                                                            : acbmp_pkg::PH_CAPTION;
          end
        end
        acbmp_pkg::PH_CAPTION: begin
          skip_nxt = skip_r - 64'd1;
          if (skip_r == 64'd1) phase_nxt = acbmp_pkg::PH_CHECK;
        end
        acbmp_pkg::PH_PIXELS: begin
          if (ci_r == 2'd0) begin
            c0_nxt = in_data.in_byte; ci_nxt = 2'd1;
          end else if (ci_r == 2'd1) begin
            c1_nxt = in_data.in_byte; ci_nxt = 2'd2;
          end else begin
            ci_nxt = 2'd0; emit = 1'b1;
            job.b0 = in_data.in_byte; job.b1 = c1_r; job.b2 = c0_r;
            col_nxt = col_inc;
            if (col_inc == wid_r) begin
              col_nxt = '0; row_nxt = row_inc;
              job.pad = 2'(3'd4 - 3'(({1'b0, wid_r[1:0]} + {wid_r[1:0], 1'b0}) & 3'd3));
              if (row_inc == hgt_r) begin
                job.last = 1'b1; phase_nxt = acbmp_pkg::PH_STOP;
              end
            end
          end
        end
        default: ;
      endcase
      if (phase_nxt == acbmp_pkg::PH_CHECK) begin
        eof_nxt = in_data.end_of_file;
      end else if (err == acbmp_pkg::ERR_NONE && in_data.end_of_file && !job.last) begin
        err = acbmp_pkg::ERR_TRUNCATED;
      end
      if (err != acbmp_pkg::ERR_NONE) begin
        phase_nxt = acbmp_pkg::PH_STOP;
        emit = 1'b1;
      end
    end
    if (err != acbmp_pkg::ERR_NONE) begin
      job = '0; job.is_err = 1'b1; job.err = err; job.last = 1'b1;
    end
    job.width  = 16'(wid_nxt);
    job.height = 16'(hgt_nxt);
  end

  assign job_valid = emit;

  always_ff @(posedge clk) begin
    prod_r <= wid_r * hgt_r;
    if (!rst_n) begin
      phase_r <= acbmp_pkg::PH_TYPE; idx_r <= '0; acc_r <= '0; skip_r <= '0;
      hlen_r <= '0; wid_r <= '0; hgt_r <= '0; wov_r <= 1'b0; hov_r <= 1'b0;
      col_r <= '0; row_r <= '0; c0_r <= '0; c1_r <= '0; ci_r <= '0; eof_r <= 1'b0;
      chk_go_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; idx_r <= idx_nxt; acc_r <= acc_nxt; skip_r <= skip_nxt;
      hlen_r <= hlen_nxt; wid_r <= wid_nxt; hgt_r <= hgt_nxt; wov_r <= wov_nxt;
      hov_r <= hov_nxt; col_r <= col_nxt; row_r <= row_nxt; c0_r <= c0_nxt;
      c1_r <= c1_nxt; ci_r <= ci_nxt; eof_r <= eof_nxt;
      chk_go_r <= chk_go_nxt;
    end
  end

endmodule

// ===== hw/rtl/acbmp_queue.sv =====
// Short job queue between parser and byte emitter.
// Uses acbmp_pkg::job_t. Full leaves one spare slot so a job never drops.
module acbmp_queue #(
  parameter int DEPTH_LOG2 = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  acbmp_pkg::job_t wr_job,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output acbmp_pkg::job_t rd_job
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  acbmp_pkg::job_t mem_r [DEPTH];
  logic [DEPTH_LOG2-1:0] wp_r, rp_r;
  logic [DEPTH_LOG2:0]   cnt_r;

  assign full     = (cnt_r >= (DEPTH_LOG2+1)'(DEPTH - 1));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (DEPTH_LOG2+1)'(wr_en) - (DEPTH_LOG2+1)'(rd_en);
    end
  end

endmodule

// ===== hw/rtl/acbmp_back.sv =====
// Back end: expands each job into BMP bytes on the output channel.
// Uses acbmp_pkg. Output is a register stage driven by a byte counter.
module acbmp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  input  acbmp_pkg::job_t      job,
  output logic                 job_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output acbmp_pkg::out_item_t out_data
);

  logic [2:0] pos_r, pos_nxt;
  logic       vld_r;
  acbmp_pkg::out_item_t dat_r, cur;
  logic [2:0] n_bytes;
  logic       load;

  assign n_bytes = job.is_err ? 3'd1 : 3'd3 + {1'b0, job.pad};

  always_comb begin
    cur.image_width  = job.width;
    cur.image_height = job.height;
    cur.error_code   = job.err;
    cur.out_last     = job.last && (pos_r == n_bytes - 3'd1);
    case (pos_r)
      3'd0:    cur.out_byte = job.is_err ? 8'd0 : job.b0;
      3'd1:    cur.out_byte = job.b1;
      3'd2:    cur.out_byte = job.b2;
      default: cur.out_byte = 8'd0;
    endcase
  end

  // Advance when the output register is empty or being drained.
  assign load    = job_valid && (!vld_r || !out_stall);
  assign job_pop = load && (pos_r == n_bytes - 3'd1);
  assign pos_nxt = job_pop ? 3'd0 : (load ? pos_r + 3'd1 : pos_r);

  always_ff @(posedge clk) begin
    if (load) dat_r <= cur;
    if (!rst_n) begin
      vld_r <= 1'b0; pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (load) vld_r <= 1'b1;
      else if (!out_stall) vld_r <= 1'b0;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = dat_r;

endmodule

// ===== hw/rtl/animation_container_to_bmp_stream_unit.sv =====
// Container-to-BMP pixel stream: parser front end, job queue, byte emitter.
// Throughput: one input byte per cycle, except while the dimension check after the
// header or a full queue stalls it; each third pixel byte yields 3-6 output bytes
// at one per cycle while out_stall is low, so the emitter sets the pixel-phase rate.
// A releasing input byte goes as a job into the queue, then the output register. Reset
// (rst_n, synchronous) returns the parser to the block-type phase, empties the queue.
module animation_container_to_bmp_stream_unit #(
  parameter int DIM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  acbmp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output acbmp_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [15:0] wid_cap_r, hgt_cap_r;
  logic [31:0] max_pixels_r;
  logic job_wr, q_full, q_valid, q_pop;
  acbmp_pkg::job_t job_in, job_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_cap_r    <= 16'hFFFF;
      hgt_cap_r    <= 16'hFFFF;
      max_pixels_r <= acbmp_pkg::MAX_PIXELS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        acbmp_pkg::CFG_MAX_WIDTH:  wid_cap_r    <= cfg_data[15:0];
        acbmp_pkg::CFG_MAX_HEIGHT: hgt_cap_r    <= cfg_data[15:0];
        acbmp_pkg::CFG_MAX_PIXELS: max_pixels_r <= cfg_data;
        default: ;
      endcase
    end
  end

  acbmp_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .wid_cap(wid_cap_r), .hgt_cap(hgt_cap_r), .max_pixels(max_pixels_r),
    .job_valid(job_wr), .job_full(q_full), .job(job_in)
  );

  acbmp_queue #(.DEPTH_LOG2(2)) u_queue (
    .clk, .rst_n, .wr_en(job_wr), .wr_job(job_in), .full(q_full),
    .rd_en(q_pop), .rd_valid(q_valid), .rd_job(job_out)
  );

  acbmp_back u_back (
    .clk, .rst_n, .job_valid(q_valid), .job(job_out), .job_pop(q_pop),
    .out_valid, .out_stall, .out_data
  );

`ifndef SYNTH
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != acbmp_pkg::ERR_NONE |-> out_data.out_last)
    else $error("error result without last");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != acbmp_pkg::ERR_NONE |-> out_data.out_byte == 8'd0)
    else $error("error result with data byte");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !job_wr)
    else $error("queue overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");
`endif

endmodule

// ===== tb/tb_animation_container_to_bmp_stream_unit.sv =====
// Testbench for animation_container_to_bmp_stream_unit: drives one container stream
// with random gaps and stalls, predicts each BMP byte, and checks every transfer.
// Depends on acbmp_pkg and the unit RTL.
module tb_animation_container_to_bmp_stream_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD = 300;

  localparam int P_TYPE = 0, P_BLK_LEN = 1, P_BLK_SKIP = 2, P_CIFF_LEN = 3, P_PRE_SKIP = 4,
                 P_HSIZE = 5, P_CSIZE = 6, P_WIDTH = 7, P_HEIGHT = 8, P_CAPTION = 9,
                 P_PIXELS = 10, P_DONE = 11, P_FAILED = 12;
  localparam logic [63:0] DIM_MASK = 64'hFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  acbmp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  acbmp_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = acbmp_pkg::CFG_MAX_WIDTH;
  logic [31:0] cfg_data = '0;

  animation_container_to_bmp_stream_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser shadow state and limits
  int unsigned phase;
  int unsigned field_idx;
  logic [63:0] field_acc, skip_left, hdr_len, width_q, height_q;
  logic width_over, height_over;
  logic [15:0] col_cnt, row_cnt;
  logic [7:0] held [2];
  int unsigned color_idx;
  logic [15:0] lim_width, lim_height;
  logic [31:0] lim_pixels;

  acbmp_pkg::out_item_t bmp_bytes_due [$];
  int errors = 0;
  int bytes_sent = 0;
  int bytes_seen = 0;
  int cycles = 0;
  bit no_idle = 0;
  bit long_hold_done = 0;

  function automatic bit gather(input logic [7:0] b, output logic [63:0] v);
    field_acc = field_acc | (64'(b) << (8 * field_idx));
    if (field_idx >= 7) begin
      v = field_acc;
      field_acc = '0;
      field_idx = 0;
      return 1'b1;
    end
    field_idx++;
    v = '0;
    return 1'b0;
  endfunction

  function automatic logic [2:0] check_dims();
    if ((width_q == 0 && !width_over) || (height_q == 0 && !height_over))
      return acbmp_pkg::ERR_ZERO_SIZE;
    if (width_over || height_over || width_q > acbmp_pkg::WIDTH_LIMIT ||
        height_q > acbmp_pkg::HEIGHT_LIMIT ||
        width_q > 64'(lim_width) || height_q > 64'(lim_height) ||
        width_q * height_q > 64'(lim_pixels))
      return acbmp_pkg::ERR_TOO_LARGE;
    col_cnt = '0;
    row_cnt = '0;
    color_idx = 0;
    phase = P_PIXELS;
    return acbmp_pkg::ERR_NONE;
  endfunction

  function automatic acbmp_pkg::out_item_t mk(input logic [7:0] b, input logic last,
                                              input logic [2:0] err);
    acbmp_pkg::out_item_t r;
    r.out_byte = b;
    r.out_last = last;
    r.error_code = err;
    r.image_width = width_q[15:0];
    r.image_height = height_q[15:0];
    return r;
  endfunction

  // Work out the BMP bytes one container byte releases
  function automatic void predict_bmp(input logic [7:0] b, input logic eof);
    acbmp_pkg::out_item_t res [$];
    logic [2:0] err;
    logic [63:0] v;
    int unsigned pad;
    err = acbmp_pkg::ERR_NONE;
    if (phase == P_DONE || phase == P_FAILED) return;
    case (phase)
      P_TYPE: begin
        if (b == acbmp_pkg::BLK_CIFF) phase = P_CIFF_LEN;
        else if (b == acbmp_pkg::BLK_HEADER || b == acbmp_pkg::BLK_CREDITS) phase = P_BLK_LEN;
        else err = acbmp_pkg::ERR_BAD_TYPE;
        field_idx = 0;
        field_acc = '0;
      end
      P_BLK_LEN: if (gather(b, v)) begin
        skip_left = v;
        phase = (v != 0) ? P_BLK_SKIP : P_TYPE;
      end
      P_BLK_SKIP: begin
        skip_left--;
        if (skip_left == 0) phase = P_TYPE;
      end
      P_CIFF_LEN: if (gather(b, v)) begin
        skip_left = acbmp_pkg::PRE_SKIP_LEN;
        phase = P_PRE_SKIP;
      end
      P_PRE_SKIP: begin
        skip_left--;
        if (skip_left == 0) phase = P_HSIZE;
      end
      P_HSIZE: if (gather(b, v)) begin
        hdr_len = v;
        phase = P_CSIZE;
      end
      P_CSIZE: if (gather(b, v)) phase = P_WIDTH;
      P_WIDTH: if (gather(b, v)) begin
        width_q = v & DIM_MASK;
        width_over = v > DIM_MASK;
        phase = P_HEIGHT;
      end
      P_HEIGHT: if (gather(b, v)) begin
        height_q = v & DIM_MASK;
        height_over = v > DIM_MASK;
        if (hdr_len < acbmp_pkg::HDR_FIXED_LEN) err = acbmp_pkg::ERR_SHORT_HDR;
        else begin
          skip_left = hdr_len - acbmp_pkg::HDR_FIXED_LEN;
          if (skip_left == 0) err = check_dims();
          else phase = P_CAPTION;
        end
      end
      P_CAPTION: begin
        skip_left--;
        if (skip_left == 0) err = check_dims();
      end
      default: begin
        if (color_idx < 2) begin
          held[color_idx] = b;
          color_idx++;
        end else begin
          color_idx = 0;
          res.push_back(mk(b, 1'b0, acbmp_pkg::ERR_NONE));
          res.push_back(mk(held[1], 1'b0, acbmp_pkg::ERR_NONE));
          res.push_back(mk(held[0], 1'b0, acbmp_pkg::ERR_NONE));
          col_cnt = col_cnt + 16'd1;
          if (64'(col_cnt) == width_q) begin
            col_cnt = '0;
            row_cnt = row_cnt + 16'd1;
            pad = (4 - ((3 * width_q) & 3)) & 3;
            repeat (pad) res.push_back(mk(8'd0, 1'b0, acbmp_pkg::ERR_NONE));
            if (64'(row_cnt) == height_q) begin
              phase = P_DONE;
              res[res.size() - 1].out_last = 1'b1;
            end
          end
        end
      end
    endcase
    if (err == acbmp_pkg::ERR_NONE && eof && phase != P_DONE) err = acbmp_pkg::ERR_TRUNCATED;
    if (err != acbmp_pkg::ERR_NONE) begin
      phase = P_FAILED;
      res.delete();
      res.push_back(mk(8'd0, 1'b1, err));
    end
    foreach (res[i]) bmp_bytes_due.push_back(res[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof = 1'b0);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, end_of_file: eof};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_bmp(b, eof);
    bytes_sent++;
  endtask

  task automatic send_le64(input logic [63:0] v);
    for (int i = 0; i < 8; i++) send_byte(v[8 * i +: 8]);
  endtask

  // Hold the input, drain every expected byte, then let the parser settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (bmp_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      acbmp_pkg::CFG_MAX_WIDTH:  lim_width = val[15:0];
      acbmp_pkg::CFG_MAX_HEIGHT: lim_height = val[15:0];
      default:                   lim_pixels = val;
    endcase
  endtask

  task automatic test_low_limits();
    write_limit(acbmp_pkg::CFG_MAX_WIDTH, 32'd1);
    write_limit(acbmp_pkg::CFG_MAX_HEIGHT, 32'd1);
    write_limit(acbmp_pkg::CFG_MAX_PIXELS, 32'd1);
  endtask

  task automatic test_skipped_blocks();
    send_byte(acbmp_pkg::BLK_HEADER);
    send_le64(64'd4);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(acbmp_pkg::BLK_CREDITS);
    send_le64(64'd0);
    send_byte(acbmp_pkg::BLK_CREDITS);
    send_le64(64'd1);
    send_byte(8'h03);
    wait_idle();
    write_limit(acbmp_pkg::CFG_MAX_WIDTH, 32'd65535);
    write_limit(acbmp_pkg::CFG_MAX_HEIGHT, 32'd65535);
    write_limit(acbmp_pkg::CFG_MAX_PIXELS, 32'hFFFF_FFFF);
  endtask

  task automatic test_image(input int w, input int h);
    int cap;
    cap = $urandom_range(1, 4);
    send_byte(acbmp_pkg::BLK_CIFF);
    send_le64({$urandom, $urandom});
    repeat (12) send_byte(8'($urandom));
    send_le64(64'(36 + cap));
    send_le64(64'(3 * w * h));
    send_le64(64'(w));
    send_le64(64'(h));
    repeat (cap - 1) send_byte(8'($urandom));
    // Settle the height and pixel limits at the exact boundary, the width limit at or one above it, before the check
    wait_idle();
    write_limit(acbmp_pkg::CFG_MAX_WIDTH, 32'(w + $urandom_range(0, 1)));
    write_limit(acbmp_pkg::CFG_MAX_HEIGHT, 32'(h));
    write_limit(acbmp_pkg::CFG_MAX_PIXELS, 32'(w * h));
    send_byte(8'($urandom));
    for (int i = 0; i < 3 * w * h; i++) begin
      if (i % 60 == 0) no_idle = $urandom_range(0, 2) == 0;
      send_byte(8'($urandom), i == 3 * w * h - 1);
    end
    no_idle = 0;
  endtask

  task automatic test_after_done();
    repeat (10) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Receiver: random stall per transfer, one long hold-off to back up the block
  initial begin
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 16);
      if (!long_hold_done && bytes_seen >= 60) begin
        hold = LONG_HOLD;
        long_hold_done = 1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (bmp_bytes_due.size() == 0) begin
        $display("%0t: unexpected transfer byte=%h last=%b err=%0d w=%0d h=%0d", $time,
                 out_data.out_byte, out_data.out_last, out_data.error_code,
                 out_data.image_width, out_data.image_height);
        errors++;
      end else begin
        acbmp_pkg::out_item_t e;
        e = bmp_bytes_due.pop_front();
        if (out_data.out_byte !== e.out_byte || out_data.out_last !== e.out_last ||
            out_data.error_code !== e.error_code || out_data.image_width !== e.image_width ||
            out_data.image_height !== e.image_height) begin
          $display("%0t: mismatch expected byte=%h last=%b err=%0d w=%0d h=%0d", $time,
                   e.out_byte, e.out_last, e.error_code, e.image_width, e.image_height);
          $display("%0t:          actual byte=%h last=%b err=%0d w=%0d h=%0d", $time,
                   out_data.out_byte, out_data.out_last, out_data.error_code,
                   out_data.image_width, out_data.image_height);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycles, bmp_bytes_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int w, h;
    phase = P_TYPE;
    field_idx = 0;
    field_acc = '0;
    skip_left = '0;
    hdr_len = '0;
    width_q = '0;
    height_q = '0;
    width_over = 0;
    height_over = 0;
    col_cnt = '0;
    row_cnt = '0;
    held[0] = '0;
    held[1] = '0;
    color_idx = 0;
    lim_width = 16'd65535;
    lim_height = 16'd65535;
    lim_pixels = acbmp_pkg::MAX_PIXELS_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    w = $urandom_range(1, 9);
    h = 133 / w;
    test_low_limits();
    test_skipped_blocks();
    test_image(w, h);
    test_after_done();
    wait_idle();
    $display("sent %0d container bytes, checked %0d BMP bytes of a %0dx%0d image",
             bytes_sent, bytes_seen, w, h);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
